// File: sv/pmfc_pkg.sv
package pmfc_pkg;

    localparam int MAX_LEN = 32;
    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    localparam int PROB_W  = 16;
    localparam int ACC_W   = 32;
    localparam int OIDX_W  = 6;

    typedef logic [PROB_W-1:0] prob_t;
    typedef logic [ACC_W-1:0]  acc_t;
    typedef logic [CNT_W-1:0]  count_t;

    typedef enum logic {
        FUNC_LEFT  = 1'b0,
        FUNC_RIGHT = 1'b1
    } func_t;

    // per-cell control from the sequencer
    typedef struct packed {
        logic load_a;  // capture left element
        logic load_b;  // capture right element
        logic a_en;    // cell index is below the left length
        logic clear;   // zero the partial sum
        logic step;    // advance one output
    } cell_ctrl_t;

endpackage

// File: sv/pmfc_cell.sv
module pmfc_cell (
    input  logic                  aclk,
    input  pmfc_pkg::cell_ctrl_t  ctrl,
    input  pmfc_pkg::prob_t       load_data,
    input  pmfc_pkg::prob_t       x_in,
    input  pmfc_pkg::prob_t       b_in,
    input  pmfc_pkg::acc_t        s_in,
    output pmfc_pkg::prob_t       b_out,
    output pmfc_pkg::acc_t        s_out,
    output pmfc_pkg::acc_t        sum_out
);

    pmfc_pkg::prob_t a_reg;
    pmfc_pkg::prob_t b_reg;
    pmfc_pkg::acc_t  s_reg;
    pmfc_pkg::acc_t  prod;
    logic [pmfc_pkg::ACC_W:0] sum_wide;

    assign prod     = ctrl.a_en ? pmfc_pkg::acc_t'(a_reg * x_in) : '0;
    assign sum_wide = {1'b0, prod} + {1'b0, s_in};
    // products are nonnegative, so clamping each partial sum gives min(total, max)
    assign sum_out  = sum_wide[pmfc_pkg::ACC_W] ? '1 : sum_wide[pmfc_pkg::ACC_W-1:0];

    always_ff @(posedge aclk) begin
        if (ctrl.load_a) begin
            a_reg <= load_data;
        end
        if (ctrl.load_b) begin
            b_reg <= load_data;
        end else if (ctrl.step) begin
            b_reg <= b_in;
        end
        if (ctrl.clear) begin
            s_reg <= '0;
        end else if (ctrl.step) begin
            s_reg <= sum_out;
        end
    end

    assign b_out = b_reg;
    assign s_out = s_reg;

endmodule

// File: sv/pmf_sum_convolver.sv
// Linear convolution of two probability vectors (Q1.15 in, saturating Q2.30 out). Elements
// load at one transfer per cycle, left (func 0) or right (func 1), each vector closed by its
// last marker; each side keeps up to 32 elements. When the second vector closes, the input
// is held off and L+R-1 results leave in index order, one per cycle while m_ready is high,
// the final one flagged by m_last_out. The results come from the row of 32 multiply-accumulate
// cells, which steps once per result: each cell holds one left element and one partial sum
// while the right vector shifts toward cell 0, whose element is broadcast to every cell.
module pmf_sum_convolver (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_func,
    input  logic [pmfc_pkg::PROB_W-1:0]   s_prob_in,
    input  logic                          s_last,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [pmfc_pkg::ACC_W-1:0]    m_prob_out,
    output logic [pmfc_pkg::OIDX_W-1:0]   m_out_index,
    output logic                          m_last_out
);

    localparam int N = pmfc_pkg::MAX_LEN;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } state_t;

    state_t                         state_reg;
    pmfc_pkg::count_t               left_count_reg;
    pmfc_pkg::count_t               right_count_reg;
    logic                           left_done_reg;
    logic                           right_done_reg;
    logic [pmfc_pkg::OIDX_W-1:0]    n_reg;
    logic                           m_valid_reg;
    pmfc_pkg::acc_t                 prob_out_reg;
    logic [pmfc_pkg::OIDX_W-1:0]    out_index_reg;
    logic                           last_out_reg;

    logic                           in_xfer;
    logic                           to_right;
    logic                           load_left;
    logic                           load_right;
    logic                           left_done_next;
    logic                           right_done_next;
    logic                           start;
    logic                           step;
    logic                           final_step;
    logic [pmfc_pkg::CNT_W:0]       last_idx;
    pmfc_pkg::prob_t                x_bcast;

    pmfc_pkg::cell_ctrl_t           ctrl  [N];
    pmfc_pkg::prob_t                b_q   [N];
    pmfc_pkg::acc_t                 s_q   [N];
    pmfc_pkg::acc_t                 sum_d [N];

    assign s_ready   = (state_reg == ST_LOAD);
    assign in_xfer   = s_valid && s_ready;
    assign to_right  = (pmfc_pkg::func_t'(s_func) == pmfc_pkg::FUNC_RIGHT);
    assign load_left = in_xfer && !to_right && !left_done_reg
                       && (left_count_reg < pmfc_pkg::CNT_W'(N));
    assign load_right = in_xfer && to_right && !right_done_reg
                        && (right_count_reg < pmfc_pkg::CNT_W'(N));

    assign left_done_next  = left_done_reg  || (in_xfer && !to_right && s_last);
    assign right_done_next = right_done_reg || (in_xfer && to_right && s_last);
    assign start           = in_xfer && left_done_next && right_done_next;

    assign step       = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);
    assign last_idx   = {1'b0, left_count_reg} + {1'b0, right_count_reg}
                        - (pmfc_pkg::CNT_W+1)'(2);
    assign final_step = step && ((pmfc_pkg::CNT_W+1)'(n_reg) == last_idx);

    // right vector shifts toward cell 0; past its length the input is zero
    assign x_bcast = (pmfc_pkg::CNT_W'(n_reg) < right_count_reg) ? b_q[0] : '0;

    for (genvar i = 0; i < N; i++) begin : g_cell
        pmfc_pkg::prob_t b_nb;
        pmfc_pkg::acc_t  s_nb;

        if (i == N - 1) begin : g_end
            assign b_nb = '0;
            assign s_nb = '0;
        end else begin : g_mid
            assign b_nb = b_q[i+1];
            assign s_nb = s_q[i+1];
        end

        always_comb begin
            ctrl[i].load_a = load_left  && (left_count_reg  == pmfc_pkg::CNT_W'(i));
            ctrl[i].load_b = load_right && (right_count_reg == pmfc_pkg::CNT_W'(i));
            ctrl[i].a_en   = pmfc_pkg::CNT_W'(i) < left_count_reg;
            ctrl[i].clear  = start;
            ctrl[i].step   = step;
        end

        pmfc_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl[i]),
            .load_data (s_prob_in),
            .x_in      (x_bcast),
            .b_in      (b_nb),
            .s_in      (s_nb),
            .b_out     (b_q[i]),
            .s_out     (s_q[i]),
            .sum_out   (sum_d[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_LOAD;
            left_count_reg  <= '0;
            right_count_reg <= '0;
            left_done_reg   <= 1'b0;
            right_done_reg  <= 1'b0;
            n_reg           <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_LOAD: begin
                    if (load_left) begin
                        left_count_reg <= left_count_reg + pmfc_pkg::CNT_W'(1);
                    end
                    if (load_right) begin
                        right_count_reg <= right_count_reg + pmfc_pkg::CNT_W'(1);
                    end
                    if (start) begin
                        state_reg      <= ST_EMIT;
                        left_done_reg  <= 1'b0;
                        right_done_reg <= 1'b0;
                        n_reg          <= '0;
                    end else begin
                        left_done_reg  <= left_done_next;
                        right_done_reg <= right_done_next;
                    end
                end
                ST_EMIT: begin
                    if (step) begin
                        n_reg <= n_reg + pmfc_pkg::OIDX_W'(1);
                    end
                    if (final_step) begin
                        state_reg       <= ST_LOAD;
                        left_count_reg  <= '0;
                        right_count_reg <= '0;
                    end
                end
                default: begin
                    state_reg <= ST_LOAD;
                end
            endcase

            if (step) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end

        if (step) begin
            prob_out_reg  <= sum_d[0];
            out_index_reg <= n_reg;
            last_out_reg  <= final_step;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_prob_out  = prob_out_reg;
    assign m_out_index = out_index_reg;
    assign m_last_out  = last_out_reg;

endmodule

// File: sv/pmfc_checker.sv
module pmfc_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic                          s_func,
    input  logic [pmfc_pkg::PROB_W-1:0]   s_prob_in,
    input  logic                          s_last,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [pmfc_pkg::ACC_W-1:0]    m_prob_out,
    input  logic [pmfc_pkg::OIDX_W-1:0]   m_out_index,
    input  logic                          m_last_out
);

    // result held while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_prob_out)
                                && $stable(m_out_index) && $stable(m_last_out))
        else $error("result changed while stalled");

    // input is held off while a burst still has results to produce
    a_busy_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_out |-> !s_ready)
        else $error("input taken in the middle of a result burst");

    // results of a burst follow one another in index order
    a_index_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_out
        |=> m_valid && (m_out_index == $past(m_out_index) + pmfc_pkg::OIDX_W'(1)))
        else $error("result index out of order");

    // reset leaves the block empty and ready to load
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not idle after reset");

endmodule

bind pmf_sum_convolver pmfc_checker u_pmfc_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_func      (s_func),
    .s_prob_in   (s_prob_in),
    .s_last      (s_last),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_prob_out  (m_prob_out),
    .m_out_index (m_out_index),
    .m_last_out  (m_last_out)
);

// File: test/pmf_sum_convolver_tb.sv
module pmf_sum_convolver_tb;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        pmfc_pkg::acc_t              prob;
        logic [pmfc_pkg::OIDX_W-1:0] index;
        logic                        last;
    } conv_result_t;

    logic                        aclk;
    logic                        aresetn;
    logic                        s_valid;
    logic                        s_ready;
    logic                        s_func;
    logic [pmfc_pkg::PROB_W-1:0] s_prob_in;
    logic                        s_last;
    logic                        m_valid;
    logic                        m_ready;
    logic [pmfc_pkg::ACC_W-1:0]  m_prob_out;
    logic [pmfc_pkg::OIDX_W-1:0] m_out_index;
    logic                        m_last_out;

    pmf_sum_convolver dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_prob_in   (s_prob_in),
        .s_last      (s_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_prob_out  (m_prob_out),
        .m_out_index (m_out_index),
        .m_last_out  (m_last_out)
    );

    // predicted operand state, indexed by FUNC_LEFT / FUNC_RIGHT
    pmfc_pkg::prob_t op_vec[2][pmfc_pkg::MAX_LEN];
    int              op_len[2];
    bit              op_closed[2];
    conv_result_t    conv_expect_q[$];
    conv_result_t    want;

    bit idle_en;
    int err_cnt;
    int cycle_cnt;
    int loaded_items;
    int dropped_items;
    int ignored_items;
    int pair_cnt;
    int results_checked;
    int widest_sum;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still outstanding", $time,
                     conv_expect_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side: random stall bursts while idling is enabled
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (idle_en && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (conv_expect_q.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual index %0d value %h last %b",
                         $time, m_out_index, m_prob_out, m_last_out);
                err_cnt++;
            end else begin
                want = conv_expect_q.pop_front();
                results_checked++;
                if (m_prob_out !== want.prob) begin
                    $display("%0t: prob_out at index %0d: expected %h, actual %h",
                             $time, want.index, want.prob, m_prob_out);
                    err_cnt++;
                end
                if (m_out_index !== want.index) begin
                    $display("%0t: out_index: expected %0d, actual %0d",
                             $time, want.index, m_out_index);
                    err_cnt++;
                end
                if (m_last_out !== want.last) begin
                    $display("%0t: last_out at index %0d: expected %b, actual %b",
                             $time, want.index, want.last, m_last_out);
                    err_cnt++;
                end
            end
        end
    end

    task automatic predict_load(input pmfc_pkg::func_t side, input pmfc_pkg::prob_t value,
                                input bit is_last);
        int              total;
        longint unsigned acc;
        conv_result_t    r;
        if (op_closed[side]) begin
            ignored_items++;
            return;
        end
        loaded_items++;
        if (op_len[side] < pmfc_pkg::MAX_LEN) begin
            op_vec[side][op_len[side]] = value;
            op_len[side]++;
        end else begin
            dropped_items++;
        end
        if (is_last)
            op_closed[side] = 1'b1;
        if (!(op_closed[pmfc_pkg::FUNC_LEFT] && op_closed[pmfc_pkg::FUNC_RIGHT]))
            return;
        total = op_len[pmfc_pkg::FUNC_LEFT] + op_len[pmfc_pkg::FUNC_RIGHT] - 1;
        for (int k = 0; k < total; k++) begin
            acc = 0;
            for (int i = 0; i < op_len[pmfc_pkg::FUNC_LEFT]; i++) begin
                if (k >= i && (k - i) < op_len[pmfc_pkg::FUNC_RIGHT]) begin
                    acc += longint'(op_vec[pmfc_pkg::FUNC_LEFT][i])
                           * longint'(op_vec[pmfc_pkg::FUNC_RIGHT][k - i]);
                    if (acc > 64'hFFFF_FFFF)
                        acc = 64'hFFFF_FFFF;
                end
            end
            r.prob  = acc[pmfc_pkg::ACC_W-1:0];
            r.index = k[pmfc_pkg::OIDX_W-1:0];
            r.last  = (k == total - 1);
            conv_expect_q.insert(conv_expect_q.size(), r);
        end
        if (total > widest_sum)
            widest_sum = total;
        pair_cnt++;
        op_len[pmfc_pkg::FUNC_LEFT]     = 0;
        op_len[pmfc_pkg::FUNC_RIGHT]    = 0;
        op_closed[pmfc_pkg::FUNC_LEFT]  = 1'b0;
        op_closed[pmfc_pkg::FUNC_RIGHT] = 1'b0;
    endtask

    // leaves valid high after the transfer; the next call or wait_drained settles it
    task automatic send_item(input pmfc_pkg::func_t side, input pmfc_pkg::prob_t value,
                             input bit is_last);
        int gap;
        gap = 0;
        if (idle_en && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 3);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_func    <= side;
        s_prob_in <= value;
        s_last    <= is_last;
        do @(posedge aclk); while (!s_ready);
        predict_load(side, value, is_last);
    endtask

    task automatic wait_drained;
        s_valid <= 1'b0;
        do @(posedge aclk); while (conv_expect_q.size() != 0);
    endtask

    function automatic pmfc_pkg::prob_t rand_prob();
        pmfc_pkg::prob_t v;
        case ($urandom_range(0, 3))
            0, 1: v = pmfc_pkg::prob_t'($urandom_range(0, 32768));
            2:    v = pmfc_pkg::prob_t'($urandom_range(0, 65535));
            default: begin
                case ($urandom_range(0, 4))
                    0: v = 16'h0000;
                    1: v = 16'h0001;
                    2: v = 16'h7FFF;
                    3: v = 16'h8000;
                    default: v = 16'hFFFF;
                endcase
            end
        endcase
        return v;
    endfunction

    // one well-formed pair with random interleave; noisy pairs also hit the closed side
    task automatic send_pair(input int lhs_n, input int rhs_n, input bit noisy);
        int              rem[2];
        pmfc_pkg::func_t side;
        rem[pmfc_pkg::FUNC_LEFT]  = lhs_n;
        rem[pmfc_pkg::FUNC_RIGHT] = rhs_n;
        while (rem[pmfc_pkg::FUNC_LEFT] + rem[pmfc_pkg::FUNC_RIGHT] > 0) begin
            if (noisy && (rem[pmfc_pkg::FUNC_LEFT] == 0 || rem[pmfc_pkg::FUNC_RIGHT] == 0)
                    && $urandom_range(0, 3) == 0) begin
                side = (rem[pmfc_pkg::FUNC_LEFT] == 0) ? pmfc_pkg::FUNC_LEFT
                                                       : pmfc_pkg::FUNC_RIGHT;
                send_item(side, rand_prob(), 1'($urandom_range(0, 1)));
            end else begin
                if (rem[pmfc_pkg::FUNC_LEFT] == 0)
                    side = pmfc_pkg::FUNC_RIGHT;
                else if (rem[pmfc_pkg::FUNC_RIGHT] == 0)
                    side = pmfc_pkg::FUNC_LEFT;
                else
                    side = $urandom_range(0, 1) ? pmfc_pkg::FUNC_RIGHT : pmfc_pkg::FUNC_LEFT;
                rem[side]--;
                send_item(side, rand_prob(), rem[side] == 0);
            end
        end
    endtask

    // length-one left operands against right vectors of one and three elements, both orders of closing
    task automatic test_unit_vectors;
        send_item(pmfc_pkg::FUNC_LEFT, 16'h8000, 1'b1);
        send_item(pmfc_pkg::FUNC_RIGHT, 16'h8000, 1'b1);
        send_item(pmfc_pkg::FUNC_RIGHT, 16'h0000, 1'b0);
        send_item(pmfc_pkg::FUNC_RIGHT, 16'hFFFF, 1'b0);
        send_item(pmfc_pkg::FUNC_RIGHT, 16'h0001, 1'b1);
        send_item(pmfc_pkg::FUNC_LEFT, 16'h7FFF, 1'b1);
    endtask

    // two full-scale products in one sum overflow 32 bits
    task automatic test_saturation;
        send_item(pmfc_pkg::FUNC_LEFT, 16'hFFFF, 1'b0);
        send_item(pmfc_pkg::FUNC_RIGHT, 16'hFFFF, 1'b0);
        send_item(pmfc_pkg::FUNC_LEFT, 16'hFFFF, 1'b1);
        send_item(pmfc_pkg::FUNC_RIGHT, 16'hFFFF, 1'b1);
    endtask

    task automatic test_closed_side_loads;
        send_item(pmfc_pkg::FUNC_LEFT, 16'h1234, 1'b1);
        send_item(pmfc_pkg::FUNC_LEFT, 16'hAAAA, 1'b1);
        send_item(pmfc_pkg::FUNC_LEFT, 16'h5555, 1'b0);
        send_item(pmfc_pkg::FUNC_RIGHT, 16'h4000, 1'b0);
        send_item(pmfc_pkg::FUNC_RIGHT, 16'h2000, 1'b1);
        // hold the sender until the whole convolution has drained
        wait_drained();
    endtask

    task automatic test_random_pairs;
        int start;
        int lhs_n;
        int rhs_n;
        start = loaded_items;
        while (loaded_items - start < 15) begin
            lhs_n = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
            rhs_n = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
            send_pair(lhs_n, rhs_n, $urandom_range(0, 2) == 0);
        end
    endtask

    // overfills the left store by two and fills the right exactly: 63 outcomes
    task automatic test_store_full;
        send_pair(pmfc_pkg::MAX_LEN + 2, pmfc_pkg::MAX_LEN, 1'b0);
    endtask

    task automatic test_no_idle;
        int start;
        idle_en = 1'b0;
        start = loaded_items;
        while (loaded_items - start < 10)
            send_pair($urandom_range(1, 5), $urandom_range(1, 5), 1'b0);
    endtask

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_func        = pmfc_pkg::FUNC_LEFT;
        s_prob_in     = '0;
        s_last        = 1'b0;
        idle_en       = 1'b1;
        err_cnt       = 0;
        cycle_cnt     = 0;
        loaded_items  = 0;
        dropped_items = 0;
        ignored_items = 0;
        pair_cnt      = 0;
        results_checked = 0;
        widest_sum    = 0;
        op_len[pmfc_pkg::FUNC_LEFT]     = 0;
        op_len[pmfc_pkg::FUNC_RIGHT]    = 0;
        op_closed[pmfc_pkg::FUNC_LEFT]  = 1'b0;
        op_closed[pmfc_pkg::FUNC_RIGHT] = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        test_unit_vectors();
        test_saturation();
        test_closed_side_loads();
        test_random_pairs();
        test_store_full();
        test_no_idle();

        wait_drained();
        repeat (40) @(posedge aclk);
        $display("Ran %0d vector pairs (%0d loads), checked %0d results, widest sum %0d outcomes",
                 pair_cnt, loaded_items, results_checked, widest_sum);
        $display("Full-store drops: %0d, loads to a closed side ignored: %0d",
                 dropped_items, ignored_items);
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: filelist.f
sv/pmfc_pkg.sv
sv/pmfc_cell.sv
sv/pmf_sum_convolver.sv
sv/pmfc_checker.sv
test/pmf_sum_convolver_tb.sv
